[hw/rtl/gcd_pkg.sv]
// Shared types, constants and arithmetic helpers for the great-circle distance unit.
`timescale 1ns / 1ps
`default_nettype none
package gcd_pkg;

	localparam int unsigned ONE_Q30 = 32'd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
	localparam logic [32:0] DIST_SCALE = 33'd5246834913;
	localparam logic [30:0] DIST_MAX = 31'd1311768576;

	typedef logic signed [33:0] q30_t;
	typedef logic [31:0] turn_t;

	function automatic logic signed [33:0] atan_step(input int unsigned k);
		logic [31:0] t [32];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
			32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
			32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326,
			32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1,
			32'd0};
		return $signed({2'b00, t[k[4:0]]});
	endfunction

	function automatic q30_t clamp_q30(input logic signed [35:0] v);
		if (v > 36'sd1073741824)
			return 34'sd1073741824;
		if (v < -36'sd1073741824)
			return -34'sd1073741824;
		return v[33:0];
	endfunction

endpackage
`default_nettype wire

[hw/rtl/gcd_cell.sv]
// One CORDIC micro-rotation cell with a registered output, rotation or vectoring mode.
`timescale 1ns / 1ps
`default_nettype none
module gcd_cell
	import gcd_pkg::*;
#(
	parameter int unsigned SHIFT = 0,
	parameter bit VECTORING = 1'b0
) (
	input  wire  logic               clk,
	input  wire  logic               en,
	input  wire  logic signed [35:0] x_in,
	input  wire  logic signed [35:0] y_in,
	input  wire  logic signed [35:0] z_in,
	output logic signed [35:0]       x_out,
	output logic signed [35:0]       y_out,
	output logic signed [35:0]       z_out
);
	logic signed [35:0] dx, dy, at;
	logic dir;

	always_comb begin
		dx = x_in >>> SHIFT;
		dy = y_in >>> SHIFT;
		at = 36'(atan_step(SHIFT));
		dir = VECTORING ? (y_in > 36'sd0) : (z_in >= 36'sd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dir) begin
				x_out <= VECTORING ? x_in + dy : x_in - dy;
				y_out <= VECTORING ? y_in - dx : y_in + dx;
				z_out <= VECTORING ? z_in + at : z_in - at;
			end else begin
				x_out <= VECTORING ? x_in - dy : x_in + dy;
				y_out <= VECTORING ? y_in + dx : y_in - dx;
				z_out <= VECTORING ? z_in - at : z_in + at;
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/gcd_chain.sv]
// Row of CORDIC cells forming one pipelined sin/cos or atan2 unit.
`timescale 1ns / 1ps
`default_nettype none
module gcd_chain
	import gcd_pkg::*;
#(
	parameter int unsigned STEPS = 24,
	parameter bit VECTORING = 1'b0
) (
	input  wire  logic               clk,
	input  wire  logic [STEPS-1:0]   en,
	input  wire  logic signed [35:0] x_in,
	input  wire  logic signed [35:0] y_in,
	input  wire  logic signed [35:0] z_in,
	output logic signed [35:0]       x_out,
	output logic signed [35:0]       y_out,
	output logic signed [35:0]       z_out
);
	logic signed [35:0] xs [STEPS+1];
	logic signed [35:0] ys [STEPS+1];
	logic signed [35:0] zs [STEPS+1];

	assign xs[0] = x_in;
	assign ys[0] = y_in;
	assign zs[0] = z_in;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		gcd_cell #(.SHIFT(i % 32), .VECTORING(VECTORING)) u_cell (
			.clk(clk), .en(en[i]),
			.x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
			.x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
		);
	end

	assign x_out = xs[STEPS];
	assign y_out = ys[STEPS];
	assign z_out = zs[STEPS];
endmodule
`default_nettype wire

[hw/rtl/gcd_sqrt.sv]
// Pipelined restoring square root of a Q30 value, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module gcd_sqrt (
	input  wire  logic        clk,
	input  wire  logic [30:0] en,
	input  wire  logic [30:0] a_in,
	output logic [30:0]       root
);
	logic [61:0] rem [32];
	logic [30:0] res [32];

	assign rem[0] = {1'b0, a_in, 30'd0};
	assign res[0] = '0;

	for (genvar i = 0; i < 31; i++) begin : g_bit
		always_ff @(posedge clk) begin
			if (en[i]) begin
				if ({1'b0, rem[i] >> (2 * (30 - i))} >= {30'd0, res[i], 2'b01}) begin
					rem[i+1] <= rem[i] - ({29'd0, res[i], 2'b01} << (2 * (30 - i)));
					res[i+1] <= {res[i][29:0], 1'b1};
				end else begin
					rem[i+1] <= rem[i];
					res[i+1] <= {res[i][29:0], 1'b0};
				end
			end
		end
	end

	assign root = res[31];
endmodule
`default_nettype wire

[hw/rtl/great_circle_distance_unit.sv]
// Top level of the pipelined haversine great-circle distance unit.
// Accepts one request per cycle while in_stall is low and returns each distance after
// the two-stage degree to binary angle conversion, the fold stage, the two CORDIC cell
// rows, the clamp and multiply stages, the 31-stage square root and the scale and
// saturate stages. The pipeline only advances when the output register is free or
// being taken, so stalls hold every stage.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance_unit
	import gcd_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = 24,
	parameter int unsigned ANGLE_FRAC_BITS = 22
) (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  logic               in_valid,
	output logic                     in_stall,
	input  wire  logic signed [29:0] start_latitude,
	input  wire  logic signed [30:0] start_longitude,
	input  wire  logic signed [29:0] end_latitude,
	input  wire  logic signed [30:0] end_longitude,
	output logic                     out_valid,
	input  wire  logic               out_stall,
	output logic [30:0]              distance_km
);
	localparam int unsigned DEPTH = 2 * CORDIC_STEPS + 42;
	localparam int unsigned TSH = 32 - ANGLE_FRAC_BITS;
	localparam int unsigned NW = TSH + 29;
	localparam int unsigned RS = NW + 7;
	localparam int unsigned MW = RS - 6;
	localparam int unsigned SW = NW + MW - 23;
	localparam logic [63:0] RECIP = ((64'd1 << RS) + 64'd89) / 64'd90;
	localparam logic [23:0] RECIP_LO = RECIP[23:0];
	localparam logic [MW-25:0] RECIP_HI = RECIP[MW-1:24];

	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[DEPTH-1];

	logic signed [30:0] ang_in [4];
	assign ang_in[0] = 31'(start_latitude);
	assign ang_in[1] = start_longitude;
	assign ang_in[2] = 31'(end_latitude);
	assign ang_in[3] = end_longitude;

	// stage 1: magnitude times reciprocal of 360, split in two partial products
	logic [3:0] sg_s1;
	logic [NW+23:0] pl_s1 [4];
	logic [NW+MW-25:0] ph_s1 [4];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				logic [30:0] u;
				logic [NW-1:0] n;
				u = ang_in[k][30] ? -ang_in[k] : ang_in[k];
				n = (NW'(u) << (TSH - 2)) + NW'(45);
				sg_s1[k] <= ang_in[k][30];
				pl_s1[k] <= {24'd0, n} * {{NW{1'b0}}, RECIP_LO};
				ph_s1[k] <= {{(MW-24){1'b0}}, n} * {{NW{1'b0}}, RECIP_HI};
			end
		end
	end

	// stage 2: binary angles
	turn_t turn_s2 [4];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				logic [SW-1:0] sum;
				turn_t mag;
				sum = {1'b0, ph_s1[k]} + SW'(pl_s1[k] >> 24);
				mag = 32'(sum >> (RS - 24));
				turn_s2[k] <= sg_s1[k] ? -mag : mag;
			end
		end
	end

	// stage 3: folded CORDIC inputs
	turn_t ang [4];
	logic [3:0] neg_s2;
	logic signed [35:0] z0_s2 [4];
	always_comb begin
		turn_t d;
		d = turn_s2[2] - turn_s2[0];
		ang[0] = {1'b0, d[31:1]};
		d = turn_s2[3] - turn_s2[1];
		ang[1] = {1'b0, d[31:1]};
		ang[2] = turn_s2[0];
		ang[3] = turn_s2[2];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				turn_t a;
				logic n;
				n = ang[k][31] ^ ang[k][30];
				a = n ? ang[k] + 32'h8000_0000 : ang[k];
				neg_s2[k] <= n;
				z0_s2[k] <= 36'($signed(a));
			end
		end
	end

	logic [CORDIC_STEPS-1:0] cen;
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_en
		assign cen[i] = adv;
	end

	logic signed [35:0] cx [4];
	logic signed [35:0] cy [4];
	logic signed [35:0] cz [4];
	for (genvar k = 0; k < 4; k++) begin : g_sc
		gcd_chain #(.STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_sc (
			.clk(clk), .en(cen),
			.x_in(36'(CORDIC_GAIN)), .y_in(36'sd0), .z_in(z0_s2[k]),
			.x_out(cx[k]), .y_out(cy[k]), .z_out(cz[k])
		);
	end

	logic [3:0] neg_d [CORDIC_STEPS];
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_d[0] <= neg_s2;
			for (int i = 1; i < CORDIC_STEPS; i++) neg_d[i] <= neg_d[i-1];
		end
	end

	// stage: clamp and sign
	q30_t slat_s3, slon_s3, c1_s3, c2_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			slat_s3 <= clamp_q30(neg_d[CORDIC_STEPS-1][0] ? -cy[0] : cy[0]);
			slon_s3 <= clamp_q30(neg_d[CORDIC_STEPS-1][1] ? -cy[1] : cy[1]);
			c1_s3 <= clamp_q30(neg_d[CORDIC_STEPS-1][2] ? -cx[2] : cx[2]);
			c2_s3 <= clamp_q30(neg_d[CORDIC_STEPS-1][3] ? -cx[3] : cx[3]);
		end
	end

	function automatic q30_t mulq(input q30_t a, input q30_t b);
		logic signed [67:0] p;
		p = 68'(a) * 68'(b) + 68'sd536870912;
		return 34'(p >>> 30);
	endfunction

	q30_t sl2_s4, sn2_s4, cc_s4, sl2_s5, t_s5;
	logic signed [35:0] a_s6;
	logic [30:0] a_s7, b_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			sl2_s4 <= mulq(slat_s3, slat_s3);
			sn2_s4 <= mulq(slon_s3, slon_s3);
			cc_s4 <= mulq(c1_s3, c2_s3);
			sl2_s5 <= sl2_s4;
			t_s5 <= mulq(cc_s4, sn2_s4);
			a_s6 <= 36'(sl2_s5) + 36'(t_s5);
			if (a_s6 < 0) begin
				a_s7 <= '0;
			end else if (a_s6 > 36'sd1073741824) begin
				a_s7 <= 31'(ONE_Q30);
			end else begin
				a_s7 <= a_s6[30:0];
			end
		end
	end
	assign b_s7 = 31'(ONE_Q30) - a_s7;

	logic [30:0] sen;
	assign sen = {31{adv}};
	logic [30:0] ra, rb;
	gcd_sqrt u_sqa (.clk(clk), .en(sen), .a_in(a_s7), .root(ra));
	gcd_sqrt u_sqb (.clk(clk), .en(sen), .a_in(b_s7), .root(rb));

	logic signed [35:0] vx, vy, vz;
	gcd_chain #(.STEPS(CORDIC_STEPS), .VECTORING(1'b1)) u_at (
		.clk(clk), .en(cen),
		.x_in({5'd0, rb}), .y_in({5'd0, ra}), .z_in(36'sd0),
		.x_out(vx), .y_out(vy), .z_out(vz)
	);

	logic [30:0] z_s8;
	logic [63:0] d_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (vz < 0) begin
				z_s8 <= '0;
			end else if (vz > 36'sd1073741824) begin
				z_s8 <= 31'(ONE_Q30);
			end else begin
				z_s8 <= vz[30:0];
			end
			d_s9 <= ({33'd0, z_s8} * {31'd0, DIST_SCALE} + 64'h8000_0000) >> 32;
			distance_km <= (d_s9 > 64'(DIST_MAX)) ? DIST_MAX : d_s9[30:0];
		end
	end
endmodule
`default_nettype wire
